### rtl/core/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### rtl/core/nbt_pkg.sv
// Shared types, codes and helpers for the NBT tag stream parser.
package nbt_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int OFFSET_BITS_DEF = 32;
   localparam int QDEPTH          = 4;
   localparam int RSP_TDATA_W     = 80;

   // parse phases
   localparam logic [3:0] PH_TYPE      = 4'd0;
   localparam logic [3:0] PH_NAME_HI   = 4'd1;
   localparam logic [3:0] PH_NAME_LO   = 4'd2;
   localparam logic [3:0] PH_NAME_SKIP = 4'd3;
   localparam logic [3:0] PH_FIXED     = 4'd4;
   localparam logic [3:0] PH_LEN       = 4'd5;
   localparam logic [3:0] PH_LIST_TYPE = 4'd6;
   localparam logic [3:0] PH_DATA      = 4'd7;

   // event codes
   localparam logic [2:0] EV_RECORD    = 3'd0;
   localparam logic [2:0] EV_OK        = 3'd1;
   localparam logic [2:0] EV_TRUNC     = 3'd2;
   localparam logic [2:0] EV_UNKNOWN   = 3'd3;
   localparam logic [2:0] EV_STRAY_END = 3'd4;
   localparam logic [2:0] EV_OVERFLOW  = 3'd5;
   localparam logic [2:0] EV_UNCLOSED  = 3'd6;

   // NBT type numbers
   localparam logic [3:0] TY_END      = 4'd0;
   localparam logic [3:0] TY_BYTES    = 4'd7;
   localparam logic [3:0] TY_STRING   = 4'd8;
   localparam logic [3:0] TY_LIST     = 4'd9;
   localparam logic [3:0] TY_COMPOUND = 4'd10;

   // payload classes
   localparam logic [2:0] PK_FIXED = 3'd0;
   localparam logic [2:0] PK_LEN   = 3'd1;
   localparam logic [2:0] PK_LIST  = 3'd2;
   localparam logic [2:0] PK_COMP  = 3'd3;
   localparam logic [2:0] PK_BAD   = 3'd4;

   typedef struct packed {
      logic        is_list_item;
      logic [4:0]  nest_depth;
      logic [30:0] element_count;
      logic [31:0] payload_offset;
      logic [3:0]  nbt_type;
      logic [2:0]  event_res;
   } nbt_res_type;

   typedef struct packed {
      logic [1:0]  cnt;
      nbt_res_type a;
      nbt_res_type b;
   } nbt_push_type;

   typedef struct packed {
      nbt_res_type res;
      logic        last;
   } nbt_qent_type;

   function automatic logic [3:0] fixed_size(input logic [3:0] t);
      case (t)
         4'd1:    fixed_size = 4'd1;
         4'd2:    fixed_size = 4'd2;
         4'd3:    fixed_size = 4'd4;
         4'd4:    fixed_size = 4'd8;
         4'd5:    fixed_size = 4'd4;
         4'd6:    fixed_size = 4'd8;
         default: fixed_size = 4'd0;
      endcase
   endfunction

   function automatic logic [2:0] payload_kind(input logic [3:0] t);
      case (t) inside
         [4'd1:4'd6]:         payload_kind = PK_FIXED;
         TY_BYTES, TY_STRING: payload_kind = PK_LEN;
         TY_LIST:             payload_kind = PK_LIST;
         TY_COMPOUND:         payload_kind = PK_COMP;
         default:             payload_kind = PK_BAD;
      endcase
   endfunction

   function automatic nbt_res_type mk_event(input logic [2:0] code);
      mk_event           = '0;
      mk_event.event_res = code;
   endfunction

endpackage

### rtl/core/nbt_tag_stream_parser.sv
// Top level of the NBT tag stream parser: frame stack memory and byte sequencer.
//
// Input channel req_*: one stream byte per beat in req_tdata[7:0]; req_tlast
// marks the final byte of a stream. Result channel rsp_*: one result per beat
// (tag record, verdict or error); rsp_tlast marks the last result of a byte.
// A byte yields zero, one or two results.
//
// A byte passes through three steps: accept with the stack top read, settle on the
// registered top entry, and the byte step. Each exhausted list popped before a type
// byte repeats the settle step (one read per pop), a compound list element pushed
// there adds a push step (single write port), an error found while settling ends
// the byte without a byte step, and bytes after an error take only the accept step.
// Results enter the queue at the end of the last step of a byte.
//
// A four-entry result queue parts the channels; a new byte is taken while up
// to two results still wait. When the queue holds more than two results,
// req_tready drops until no more than two are left.
// Reset clears the parser state and the queue; the frame memory is not
// cleared, only entries below the frame count are ever read. After the last
// byte of a stream the parser starts over on its own.
`include "assert_macros.svh"

module nbt_tag_stream_parser import nbt_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // data_byte[7:0]
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // event_res[2:0], nbt_type[6:3], payload_offset[38:7], element_count[69:39],
   // nest_depth[74:70], is_list_item[75], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int OB = OFFSET_BITS;

   localparam logic [1:0] S_IN   = 2'd0;
   localparam logic [1:0] S_SET  = 2'd1;
   localparam logic [1:0] S_PUSH = 2'd2;
   localparam logic [1:0] S_TAKE = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [7:0]    byte_ff, byte_in;
   logic          last_ff, last_in;
   logic [CW-1:0] fc_ff, fc_in;
   logic [3:0]    phase_ff, phase_in;
   logic [31:0]   skip_ff, skip_in;
   logic [31:0]   lacc_ff, lacc_in;
   logic [3:0]    ct_ff, ct_in;
   logic [3:0]    plt_ff, plt_in;
   logic [OB-1:0] off_ff, off_in;
   logic          failed_ff, failed_in;
   logic          top_list_ff, top_list_in;
   nbt_res_type   held_ff, held_in;
   logic          held_v_ff, held_v_in;

   // frame entry: list flag [35], element type [34:31], elements left [30:0]
   logic [35:0]   frame_mem [STACK_DEPTH];
   logic [35:0]   rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [35:0]   wr_data;

   logic          accept, top_list, do_open, rec_v, evt_v, fin;
   logic [OB-1:0] off_nx, open_off;
   logic          cur_item;
   logic [31:0]   skip_dec, lacc_new;
   nbt_res_type   rec, evt;
   nbt_push_type  push;

   logic          q_full_hint;
   logic [2:0]    q_used_ff, q_used_in;

   assign accept   = req_tvalid && req_tready;
   assign top_list = (fc_ff != '0) && rd_data_ff[35];
   assign off_nx   = off_ff + OB'(1);
   assign skip_dec = skip_ff - 32'd1;

   always_comb begin
      state_in    = state_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      fc_in       = fc_ff;
      phase_in    = phase_ff;
      skip_in     = skip_ff;
      lacc_in     = lacc_ff;
      ct_in       = ct_ff;
      plt_in      = plt_ff;
      off_in      = off_ff;
      failed_in   = failed_ff;
      top_list_in = top_list_ff;
      held_in     = held_ff;
      held_v_in   = held_v_ff;
      rd_addr     = AW'(fc_ff - CW'(1));
      wr_en       = 1'b0;
      wr_addr     = AW'(fc_ff);
      wr_data     = '0;
      do_open     = 1'b0;
      open_off    = off_nx;
      cur_item    = top_list_ff;
      rec_v       = 1'b0;
      rec         = '0;
      evt_v       = 1'b0;
      evt         = '0;
      lacc_new    = lacc_ff;
      push        = '0;

      case (state_ff)
         S_IN: begin
            if (accept) begin
               byte_in   = req_tdata;
               last_in   = req_tlast;
               held_v_in = 1'b0;
               if (failed_ff) begin
                  // dead stream: count bytes, restart on the last one
                  if (req_tlast) begin
                     fc_in     = '0;
                     phase_in  = PH_TYPE;
                     skip_in   = '0;
                     lacc_in   = '0;
                     ct_in     = '0;
                     plt_in    = '0;
                     off_in    = '0;
                     failed_in = 1'b0;
                  end else begin
                     off_in = off_nx;
                  end
               end else begin
                  state_in = S_SET;
               end
            end
         end
         S_SET: begin
            state_in = S_TAKE;
            if (phase_ff == PH_TYPE && top_list) begin
               if (rd_data_ff[30:0] == 31'd0) begin
                  // exhausted list: pop and read the next frame down
                  fc_in    = fc_ff - CW'(1);
                  rd_addr  = AW'(fc_ff - CW'(2));
                  state_in = S_SET;
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = AW'(fc_ff - CW'(1));
                  wr_data     = {rd_data_ff[35:31], rd_data_ff[30:0] - 31'd1};
                  top_list_in = 1'b1;
                  if (rd_data_ff[34:31] == TY_END) begin
                     failed_in = 1'b1;
                     evt_v     = 1'b1;
                     evt       = mk_event(EV_STRAY_END);
                  end else begin
                     ct_in    = rd_data_ff[34:31];
                     do_open  = 1'b1;
                     open_off = off_ff;
                     cur_item = 1'b1;
                  end
               end
            end else begin
               top_list_in = top_list;
            end
         end
         S_PUSH: begin
            wr_en       = 1'b1;
            wr_addr     = AW'(fc_ff);
            wr_data     = '0;
            fc_in       = fc_ff + CW'(1);
            top_list_in = 1'b0;
            state_in    = S_TAKE;
         end
         default: begin
            case (phase_ff)
               PH_TYPE: begin
                  if (byte_ff == 8'd0) begin
                     if (fc_ff == '0) begin
                        failed_in = 1'b1;
                        evt_v     = 1'b1;
                        evt       = mk_event(EV_STRAY_END);
                     end else begin
                        fc_in = fc_ff - CW'(1);
                     end
                  end else if (byte_ff > 8'd10) begin
                     failed_in = 1'b1;
                     evt_v     = 1'b1;
                     evt       = mk_event(EV_UNKNOWN);
                  end else begin
                     ct_in    = byte_ff[3:0];
                     phase_in = PH_NAME_HI;
                  end
               end
               PH_NAME_HI: begin
                  lacc_in  = {16'd0, byte_ff, 8'd0};
                  phase_in = PH_NAME_LO;
               end
               PH_NAME_LO: begin
                  lacc_new = lacc_ff | {24'd0, byte_ff};
                  lacc_in  = lacc_new;
                  if (lacc_new == 32'd0) begin
                     do_open = 1'b1;
                  end else begin
                     skip_in  = lacc_new;
                     phase_in = PH_NAME_SKIP;
                  end
               end
               PH_NAME_SKIP: begin
                  skip_in = skip_dec;
                  if (skip_dec == 32'd0) begin
                     do_open = 1'b1;
                  end
               end
               PH_FIXED: begin
                  skip_in = skip_dec;
                  if (skip_dec == 32'd0) begin
                     rec_v = 1'b1;
                     rec   = '{is_list_item: top_list_ff, nest_depth: 5'(fc_ff),
                               element_count: 31'd1,
                               payload_offset: 32'(off_nx - OB'(fixed_size(ct_ff))),
                               nbt_type: ct_ff, event_res: EV_RECORD};
                     phase_in = PH_TYPE;
                  end
               end
               PH_LEN: begin
                  lacc_new = {lacc_ff[23:0], byte_ff};
                  lacc_in  = lacc_new;
                  skip_in  = skip_dec;
                  if (skip_dec == 32'd0) begin
                     if (ct_ff == TY_LIST) begin
                        if (lacc_new[31]) begin
                           failed_in = 1'b1;
                           evt_v     = 1'b1;
                           evt       = mk_event(EV_TRUNC);
                        end else if (fc_ff >= CW'(STACK_DEPTH)) begin
                           failed_in = 1'b1;
                           evt_v     = 1'b1;
                           evt       = mk_event(EV_OVERFLOW);
                        end else begin
                           rec_v = 1'b1;
                           rec   = '{is_list_item: top_list_ff, nest_depth: 5'(fc_ff),
                                     element_count: lacc_new[30:0],
                                     payload_offset: 32'(off_nx),
                                     nbt_type: ct_ff, event_res: EV_RECORD};
                           wr_en    = 1'b1;
                           wr_addr  = AW'(fc_ff);
                           wr_data  = {1'b1, plt_ff, lacc_new[30:0]};
                           fc_in    = fc_ff + CW'(1);
                           phase_in = PH_TYPE;
                        end
                     end else if (ct_ff == TY_BYTES && lacc_new[31]) begin
                        failed_in = 1'b1;
                        evt_v     = 1'b1;
                        evt       = mk_event(EV_TRUNC);
                     end else if (lacc_new == 32'd0) begin
                        rec_v = 1'b1;
                        rec   = '{is_list_item: top_list_ff, nest_depth: 5'(fc_ff),
                                  element_count: 31'd0, payload_offset: 32'(off_nx),
                                  nbt_type: ct_ff, event_res: EV_RECORD};
                        phase_in = PH_TYPE;
                     end else begin
                        skip_in  = lacc_new;
                        phase_in = PH_DATA;
                     end
                  end
               end
               PH_LIST_TYPE: begin
                  plt_in   = (byte_ff > 8'd15) ? 4'd15 : byte_ff[3:0];
                  phase_in = PH_LEN;
                  skip_in  = 32'd4;
                  lacc_in  = '0;
               end
               PH_DATA: begin
                  skip_in = skip_dec;
                  if (skip_dec == 32'd0) begin
                     rec_v = 1'b1;
                     rec   = '{is_list_item: top_list_ff, nest_depth: 5'(fc_ff),
                               element_count: lacc_ff[30:0],
                               payload_offset: 32'(off_nx - OB'(lacc_ff)),
                               nbt_type: ct_ff, event_res: EV_RECORD};
                     phase_in = PH_TYPE;
                  end
               end
               default: phase_in = PH_TYPE;
            endcase
         end
      endcase

      // payload start, shared by the settle and byte steps
      if (do_open) begin
         case (payload_kind(ct_in))
            PK_FIXED: begin
               phase_in = PH_FIXED;
               skip_in  = 32'(fixed_size(ct_in));
            end
            PK_LEN: begin
               phase_in = PH_LEN;
               skip_in  = (ct_in == TY_BYTES) ? 32'd4 : 32'd2;
               lacc_in  = '0;
            end
            PK_LIST: phase_in = PH_LIST_TYPE;
            PK_COMP: begin
               if (fc_ff >= CW'(STACK_DEPTH)) begin
                  failed_in = 1'b1;
                  evt_v     = 1'b1;
                  evt       = mk_event(EV_OVERFLOW);
               end else begin
                  rec_v = 1'b1;
                  rec   = '{is_list_item: cur_item, nest_depth: 5'(fc_ff),
                            element_count: 31'd0, payload_offset: 32'(open_off),
                            nbt_type: ct_in, event_res: EV_RECORD};
                  phase_in = PH_TYPE;
                  if (state_ff == S_SET) begin
                     // write port busy with the list count update
                     state_in = S_PUSH;
                  end else begin
                     wr_en       = 1'b1;
                     wr_addr     = AW'(fc_ff);
                     wr_data     = '0;
                     fc_in       = fc_ff + CW'(1);
                  end
               end
            end
            default: begin
               failed_in = 1'b1;
               evt_v     = 1'b1;
               evt       = mk_event(EV_UNKNOWN);
            end
         endcase
      end

      fin = (state_ff == S_TAKE) || (state_ff == S_SET && failed_in);

      if (fin) begin
         if (!failed_in && last_ff) begin
            evt_v = 1'b1;
            if (phase_in != PH_TYPE) begin
               evt = mk_event(EV_TRUNC);
            end else if (fc_in != '0) begin
               evt = mk_event(EV_UNCLOSED);
            end else begin
               evt = mk_event(EV_OK);
            end
         end
         if (held_v_ff) begin
            push.a   = held_ff;
            push.cnt = 2'd1;
         end
         if (rec_v) begin
            if (push.cnt == 2'd0) push.a = rec;
            else                  push.b = rec;
            push.cnt = push.cnt + 2'd1;
         end
         if (evt_v) begin
            if (push.cnt == 2'd0) push.a = evt;
            else                  push.b = evt;
            push.cnt = push.cnt + 2'd1;
         end
         held_v_in = 1'b0;
         state_in  = S_IN;
         if (last_ff) begin
            fc_in     = '0;
            phase_in  = PH_TYPE;
            skip_in   = '0;
            lacc_in   = '0;
            ct_in     = '0;
            plt_in    = '0;
            off_in    = '0;
            failed_in = 1'b0;
         end else begin
            off_in = off_nx;
         end
      end else if (rec_v) begin
         held_in   = rec;
         held_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      held_ff <= held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IN;
         fc_ff       <= '0;
         phase_ff    <= PH_TYPE;
         skip_ff     <= '0;
         lacc_ff     <= '0;
         ct_ff       <= '0;
         plt_ff      <= '0;
         off_ff      <= '0;
         failed_ff   <= 1'b0;
         top_list_ff <= 1'b0;
         held_v_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fc_ff       <= fc_in;
         phase_ff    <= phase_in;
         skip_ff     <= skip_in;
         lacc_ff     <= lacc_in;
         ct_ff       <= ct_in;
         plt_ff      <= plt_in;
         off_ff      <= off_in;
         failed_ff   <= failed_in;
         top_list_ff <= top_list_in;
         held_v_ff   <= held_v_in;
      end
   end

   // ready needs room for the two results a byte can make
   assign req_tready = (state_ff == S_IN) && !(rsp_tvalid && q_full_hint);

   assign q_used_in   = q_used_ff + 3'(push.cnt) - 3'(rsp_tvalid && rsp_tready);
   assign q_full_hint = (q_used_ff > 3'd2);

   always_ff @(posedge clock) begin
      if (reset) q_used_ff <= '0;
      else       q_used_ff <= q_used_in;
   end

   nbt_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `ASSERT_NEVER(a_fc_bound, clock, reset, fc_ff > CW'(STACK_DEPTH),
      "frame count past stack depth")
   `ASSERT_PROP(a_push_from_set, clock, reset,
      (state_ff == S_PUSH) |-> ($past(state_ff) == S_SET), "stray compound push cycle")
   `ASSERT_PROP(a_accept_runs, clock, reset,
      (accept && !failed_ff) |=> (state_ff == S_SET), "accepted byte not processed")

endmodule

### rtl/core/nbt_rsp_queue.sv
// Four-entry result queue; takes up to two results of one byte per cycle.
`include "assert_macros.svh"

module nbt_rsp_queue import nbt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  nbt_push_type           push,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // event_res[2:0], nbt_type[6:3], payload_offset[38:7], element_count[69:39],
   // nest_depth[74:70], is_list_item[75], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   nbt_qent_type q_ff [QDEPTH];
   logic [1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = RSP_TDATA_W'(q_ff[rd_ptr_ff].res);
   assign rsp_tlast  = q_ff[rd_ptr_ff].last;

   assign wr_ptr_in = wr_ptr_ff + push.cnt;
   assign rd_ptr_in = rd_ptr_ff + 2'(pop);
   assign cnt_in    = cnt_ff + 3'(push.cnt) - 3'(pop);

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         q_ff[wr_ptr_ff] <= '{res: push.a, last: (push.cnt == 2'd1)};
      end
      if (push.cnt == 2'd2) begin
         q_ff[wr_ptr_ff + 2'd1] <= '{res: push.b, last: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   `ASSERT_NEVER(a_q_count, clock, reset, cnt_ff > 3'(QDEPTH), "result queue count too high")
   `ASSERT_NEVER(a_q_fit, clock, reset, (4'(cnt_ff) + 4'(push.cnt)) > 4'(QDEPTH),
      "result queue overrun")
   `ASSERT_PROP(a_q_pop, clock, reset,
      (pop && push.cnt == 2'd0) |=> (cnt_ff == $past(cnt_ff) - 3'd1), "queue pop lost")

endmodule

### test/nbt_checker.sv
// Scoreboard for the NBT parser: predicts results per accepted byte and checks them.
`timescale 1ns / 100ps

module nbt_checker import nbt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tlast,
   output int                     fail_count,
   output int                     pending
);

   localparam int DEPTH = STACK_DEPTH_DEF;

   // frame entry: [35] list flag, [34:31] element type, [30:0] elements left
   logic [35:0] frames [DEPTH];
   int          n_frames;
   logic [3:0]  phase;
   logic [31:0] skip_left;
   logic [31:0] len_acc;
   logic [3:0]  cur_tag;
   logic [3:0]  list_elem_tag;
   logic [31:0] byte_pos;
   bit          aborted;

   nbt_res_type  new_res [2];
   int           n_new;
   nbt_qent_type expected_q [$];

   function automatic int tag_width(input logic [3:0] t);
      case (t)
         4'd1:       return 1;
         4'd2:       return 2;
         4'd3, 4'd5: return 4;
         4'd4, 4'd6: return 8;
         default:    return 0;
      endcase
   endfunction

   function automatic bit top_list();
      return n_frames > 0 && frames[n_frames-1][35];
   endfunction

   task automatic post(input logic [2:0] ev, input logic [3:0] ty, input logic [31:0] o,
                       input logic [30:0] cnt, input logic [4:0] d, input logic li);
      nbt_res_type r;
      if (n_new >= 2) return;
      r.event_res      = ev;
      r.nbt_type       = ty;
      r.payload_offset = o;
      r.element_count  = cnt;
      r.nest_depth     = d;
      r.is_list_item   = li;
      new_res[n_new]   = r;
      n_new++;
   endtask

   task automatic note_tag(input logic [31:0] o, input logic [31:0] cnt);
      post(EV_RECORD, cur_tag, o, cnt[30:0], n_frames[4:0], top_list());
   endtask

   task automatic abort(input logic [2:0] code);
      aborted = 1;
      post(code, '0, '0, '0, '0, 1'b0);
   endtask

   task automatic clear_state();
      n_frames = 0; phase = PH_TYPE; skip_left = 0; len_acc = 0;
      cur_tag = 0; list_elem_tag = 0; byte_pos = 0; aborted = 0;
   endtask

   task automatic begin_payload(input logic [31:0] nxt);
      if (tag_width(cur_tag) != 0) begin
         phase = PH_FIXED;
         skip_left = tag_width(cur_tag);
      end else if (cur_tag == TY_BYTES || cur_tag == TY_STRING) begin
         phase = PH_LEN;
         skip_left = (cur_tag == TY_BYTES) ? 4 : 2;
         len_acc = 0;
      end else if (cur_tag == TY_LIST) begin
         phase = PH_LIST_TYPE;
      end else if (cur_tag == TY_COMPOUND) begin
         if (n_frames >= DEPTH) begin
            abort(EV_OVERFLOW);
            return;
         end
         note_tag(nxt, 0);
         frames[n_frames] = '0;
         n_frames++;
         phase = PH_TYPE;
      end else begin
         abort(EV_UNKNOWN);
      end
   endtask

   // pop exhausted lists, then start the next list element if one is due
   task automatic close_lists();
      logic [35:0] f;
      while (!aborted && top_list()) begin
         f = frames[n_frames-1];
         if (f[30:0] == 0) begin
            n_frames--;
            continue;
         end
         frames[n_frames-1] = f - 1;
         if (f[34:31] == TY_END) begin
            abort(EV_STRAY_END);
            return;
         end
         cur_tag = f[34:31];
         begin_payload(byte_pos);
         return;
      end
   endtask

   task automatic length_done(input logic [31:0] nxt);
      if (cur_tag == TY_LIST) begin
         if (len_acc[31]) begin
            abort(EV_TRUNC);
            return;
         end
         if (n_frames >= DEPTH) begin
            abort(EV_OVERFLOW);
            return;
         end
         note_tag(nxt, len_acc);
         frames[n_frames] = {1'b1, list_elem_tag, len_acc[30:0]};
         n_frames++;
         phase = PH_TYPE;
      end else if (cur_tag == TY_BYTES && len_acc[31]) begin
         abort(EV_TRUNC);
      end else if (len_acc == 0) begin
         note_tag(nxt, 0);
         phase = PH_TYPE;
      end else begin
         skip_left = len_acc;
         phase = PH_DATA;
      end
   endtask

   task automatic eat_byte(input logic [7:0] b);
      logic [31:0] nxt;
      nxt = byte_pos + 1;
      case (phase)
         PH_TYPE: begin
            if (b == 8'(TY_END)) begin
               if (n_frames == 0) abort(EV_STRAY_END);
               else n_frames--;
            end else if (b > 8'(TY_COMPOUND)) begin
               abort(EV_UNKNOWN);
            end else begin
               cur_tag = b[3:0];
               phase = PH_NAME_HI;
            end
         end
         PH_NAME_HI: begin
            len_acc = {16'd0, b, 8'd0};
            phase = PH_NAME_LO;
         end
         PH_NAME_LO: begin
            len_acc = len_acc | {24'd0, b};
            if (len_acc == 0) begin
               begin_payload(nxt);
            end else begin
               skip_left = len_acc;
               phase = PH_NAME_SKIP;
            end
         end
         PH_NAME_SKIP: begin
            skip_left--;
            if (skip_left == 0) begin_payload(nxt);
         end
         PH_FIXED: begin
            skip_left--;
            if (skip_left == 0) begin
               note_tag(nxt - 32'(tag_width(cur_tag)), 32'd1);
               phase = PH_TYPE;
            end
         end
         PH_LEN: begin
            len_acc = {len_acc[23:0], b};
            skip_left--;
            if (skip_left == 0) length_done(nxt);
         end
         PH_LIST_TYPE: begin
            list_elem_tag = (b > 8'd15) ? 4'd15 : b[3:0];
            phase = PH_LEN;
            skip_left = 4;
            len_acc = 0;
         end
         PH_DATA: begin
            skip_left--;
            if (skip_left == 0) begin
               note_tag(nxt - len_acc, len_acc);
               phase = PH_TYPE;
            end
         end
         default: phase = PH_TYPE;
      endcase
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic lst);
      nbt_qent_type e;
      n_new = 0;
      if (!aborted) begin
         if (phase == PH_TYPE) close_lists();
         if (!aborted) eat_byte(b);
         if (!aborted && lst) begin
            if (phase != PH_TYPE) abort(EV_TRUNC);
            else if (n_frames > 0) abort(EV_UNCLOSED);
            else post(EV_OK, '0, '0, '0, '0, 1'b0);
         end
      end
      byte_pos++;
      if (lst) clear_state();
      for (int i = 0; i < n_new; i++) begin
         e.res  = new_res[i];
         e.last = (i == n_new - 1);
         expected_q.push_back(e);
      end
   endtask

   always @(posedge clock) begin
      nbt_qent_type e;
      nbt_res_type  got;
      if (reset) begin
         clear_state();
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(nbt_res_type)-1:0];
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat, actual %p last %b", $time, got, rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (got.event_res !== e.res.event_res || got.nbt_type !== e.res.nbt_type ||
                   got.payload_offset !== e.res.payload_offset ||
                   got.element_count !== e.res.element_count ||
                   got.nest_depth !== e.res.nest_depth ||
                   got.is_list_item !== e.res.is_list_item || rsp_tlast !== e.last) begin
                  $display("%0t: result mismatch, expected %p last %b, actual %p last %b",
                           $time, e.res, e.last, got, rsp_tlast);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

### test/tb_top.sv
// Testbench top: NBT stream generator, handshake pacing and verdict.
`timescale 1ns / 100ps

module tb_top;
   import nbt_pkg::*;

   localparam logic [7:0] B_END      = 8'(TY_END);
   localparam logic [7:0] B_BYTES    = 8'(TY_BYTES);
   localparam logic [7:0] B_STRING   = 8'(TY_STRING);
   localparam logic [7:0] B_LIST     = 8'(TY_LIST);
   localparam logic [7:0] B_COMPOUND = 8'(TY_COMPOUND);

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;
   logic                   req_tlast = 0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   int                     fail_count;
   int                     pending;

   bit   quiet = 0;
   bit   long_hold = 0;
   int   idle_cycles = 0;
   int   bytes_sent = 0;
   int   streams_sent = 0;
   logic [7:0] stream_q [$];

   always #2 clock = ~clock;

   nbt_tag_stream_parser u_dut (.*);

   nbt_checker u_chk (.*);

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      repeat (8) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (60) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // valid drops at random before bytes unless quiet; stop_req drops valid before a pause
   task automatic send_stream();
      for (int i = 0; i < stream_q.size(); i++) begin
         if (!quiet && $urandom_range(0, 4) == 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         req_tvalid <= 1;
         req_tdata  <= stream_q[i];
         req_tlast  <= (i == stream_q.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         bytes_sent++;
      end
      streams_sent++;
   endtask

   task automatic stop_req();
      req_tvalid <= 0;
      req_tlast  <= 0;
   endtask

   function automatic int tag_bytes(input logic [3:0] t);
      case (t)
         4'd1:       return 1;
         4'd2:       return 2;
         4'd3, 4'd5: return 4;
         default:    return 8;
      endcase
   endfunction

   function automatic void put_name();
      int n;
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
      stream_q.push_back(8'd0);
      stream_q.push_back(n[7:0]);
      repeat (n) stream_q.push_back(8'($urandom));
   endfunction

   function automatic void put_payload(input logic [3:0] t, input int lvl);
      int n;
      logic [3:0] et;
      case (t)
         TY_BYTES, TY_STRING: begin
            n = $urandom_range(0, 4);
            if (t == TY_BYTES) begin
               stream_q.push_back(8'd0);
               stream_q.push_back(8'd0);
            end
            stream_q.push_back(8'd0);
            stream_q.push_back(n[7:0]);
            repeat (n) stream_q.push_back(8'($urandom));
         end
         TY_LIST: begin
            et = 4'($urandom_range(1, 10));
            if (lvl >= 3 && et >= TY_LIST) et = 4'd1;
            n = $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0) begin
               et = TY_END;
               n = 0;
            end
            stream_q.push_back({4'd0, et});
            stream_q.push_back(8'd0);
            stream_q.push_back(8'd0);
            stream_q.push_back(8'd0);
            stream_q.push_back(n[7:0]);
            repeat (n) put_payload(et, lvl + 1);
         end
         TY_COMPOUND: begin
            n = (lvl >= 3) ? 0 : $urandom_range(0, 3);
            repeat (n) put_named(lvl + 1);
            stream_q.push_back(B_END);
         end
         default: repeat (tag_bytes(t)) stream_q.push_back(8'($urandom));
      endcase
   endfunction

   function automatic void put_named(input int lvl);
      logic [3:0] t;
      t = 4'($urandom_range(1, 10));
      if (lvl >= 3 && t >= TY_LIST) t = 4'd3;
      stream_q.push_back({4'd0, t});
      put_name();
      put_payload(t, lvl);
   endfunction

   // one well-formed root compound, ending with its end byte
   function automatic void build_stream();
      stream_q.delete();
      stream_q.push_back(B_COMPOUND);
      put_name();
      put_payload(TY_COMPOUND, 0);
   endfunction

   task automatic directed(input logic [7:0] bytes []);
      stream_q.delete();
      foreach (bytes[i]) stream_q.push_back(bytes[i]);
      send_stream();
   endtask

   initial begin
      int mode;
      int cut;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed('{B_COMPOUND, 8'h00, 8'h00, B_END});                 // empty root
      directed('{B_END});                                           // stray end
      directed('{8'hFF, 8'h00});                                    // unknown type
      directed('{8'h01, 8'h00, 8'h00, 8'h80});                      // complete byte tag at root
      directed('{B_COMPOUND, 8'h00, 8'h00});                        // unclosed
      directed('{B_BYTES, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h7F});
      directed('{B_LIST, 8'h00, 8'h00, B_END, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00});
      directed('{B_LIST, 8'h00, 8'h00, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00});
      directed('{B_LIST, 8'h00, 8'h00, B_COMPOUND, 8'h00, 8'h00, 8'h00, 8'h02,
                 B_END, B_END});                                    // compound elements
      directed('{B_STRING, 8'h01, 8'h00, 8'hAA, 8'h00, 8'h00});     // long name, cut short
      // seventeen nested compounds: the last push overflows the stack
      stream_q.delete();
      repeat (17) begin
         stream_q.push_back(B_COMPOUND);
         stream_q.push_back(8'd0);
         stream_q.push_back(8'd0);
      end
      stream_q.push_back(B_END);
      send_stream();

      while (bytes_sent < 420) begin
         if (bytes_sent > 320) quiet = 1;
         build_stream();
         mode = $urandom_range(0, 9);
         if (mode == 7) begin
            cut = $urandom_range(1, stream_q.size());
            while (stream_q.size() > cut) void'(stream_q.pop_back());
         end else if (mode == 8) begin
            stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom);
         end else if (mode == 9) begin
            stream_q.delete();
            repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
         end
         if (streams_sent == 14) long_hold = 1;
         send_stream();
         if (streams_sent == 18) begin
            stop_req();
            @(posedge clock);
            wait (pending == 0);
         end
      end

      stop_req();
      @(posedge clock);
      wait (pending == 0);
      repeat (40) @(posedge clock);
      $display("Sent %0d bytes in %0d streams: well-formed, cut, corrupted and noise.",
               bytes_sent, streams_sent);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/nbt_pkg.sv
rtl/core/nbt_rsp_queue.sv
rtl/core/nbt_tag_stream_parser.sv
test/nbt_checker.sv
test/tb_top.sv
